FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants of the top-K score store
// Beat structs, list entry type, register map and small helpers.
// ----------------------------------------------------------------------------
package tks_pkg;

	localparam int DEPTH       = 32;
	localparam int HANDLE_BITS = 16;
	localparam int SCORE_BITS  = 32;
	localparam int KEPT_W      = 6;
	localparam int LIM_W       = 6;
	localparam int CNT_W       = 32;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_LIMIT_ROOT = 2'd0;
	localparam logic [1:0] REG_LIMIT_ELSE = 2'd1;
	localparam logic [1:0] REG_INIT_MODE  = 2'd2;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	typedef struct packed {
		logic                          func;
		logic [HANDLE_BITS-1:0]        handle;
		logic signed [SCORE_BITS-1:0]  score;
		logic                          at_root;
	} in_item_t;

	typedef struct packed {
		logic [HANDLE_BITS-1:0]        out_handle;
		logic signed [SCORE_BITS-1:0]  out_score;
		logic                          accepted;
		logic                          was_empty;
		logic                          last;
		logic [KEPT_W-1:0]             kept_count;
		logic [CNT_W-1:0]              found_total;
		logic [CNT_W-1:0]              applied_total;
	} out_item_t;

	typedef struct packed {
		logic [HANDLE_BITS-1:0]        handle;
		logic signed [SCORE_BITS-1:0]  score;
	} entry_t;

	typedef struct packed {
		logic add_en;
		logic drain_en;
	} cell_ctl_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (&c) ? c : c + CNT_W'(1);
	endfunction

endpackage

FILE: hw/rtl/tks_cell.sv
// ----------------------------------------------------------------------------
// tks_cell: one slot of the sorted chain
// Compares the candidate with its own entry; takes the candidate, the left
// neighbour's entry on insert, or the right neighbour's entry on drain.
// ----------------------------------------------------------------------------
module tks_cell import tks_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    new_ent,
	input  logic      occupied,
	input  logic      prev_gt,
	input  entry_t    left_ent,
	input  entry_t    right_ent,
	output entry_t    ent,
	output logic      cmp,
	output logic      gt
);

	entry_t ent_q;

	assign ent = ent_q;
	// strict compare: equal scores keep the older entry in front
	assign cmp = new_ent.score > ent_q.score;
	assign gt  = !occupied || cmp;

	always_ff @(posedge clk) begin
		if (ctl.drain_en) begin
			ent_q <= right_ent;
		end else if (ctl.add_en) begin
			if (gt && !prev_gt) begin
				ent_q <= new_ent;
			end else if (prev_gt) begin
				ent_q <= left_ent;
			end
		end
	end

endmodule

FILE: hw/rtl/top_k_score_store.sv
// ----------------------------------------------------------------------------
// top_k_score_store: bounded top-K list of candidates sorted by score
// Chain of cells kept in descending score order, APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken on a rising edge with start high and
//   busy low. func = add carries handle, score (signed Q16.16) and at_root.
//   Result channel: res is valid for exactly one cycle while res_valid is
//   high; there is no back-pressure, the receiver must take every beat.
//   Add: one result beat the cycle after the command; busy stays low, so a
//   new add may follow every cycle (every cell compares and shifts in
//   parallel in the same edge).
//   Drain: N result beats on consecutive cycles starting the cycle after
//   the command, best first, last marked; busy stays high while the chain
//   shifts towards cell 0, one entry a cycle. Empty list: one beat with
//   was_empty set.
//   Registers: limit_at_root (0x0), limit_elsewhere (0x4), initial_mode
//   (0x8); write only while idle. pready is tied high.
//   Reset: list empty, counters zero, limits 32, initial mode off. No
//   clearing pass: cells beyond the kept count are never shown.
// ----------------------------------------------------------------------------
module top_k_score_store import tks_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	input  in_item_t          req,
	output logic              busy,
	// result channel
	output logic              res_valid,
	output out_item_t         res,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam logic [KEPT_W-1:0] DEPTH_K = KEPT_W'(DEPTH);

	// configuration
	logic [LIM_W-1:0] lim_root_q;
	logic [LIM_W-1:0] lim_else_q;
	logic             init_q;

	// control state
	logic [KEPT_W-1:0] count_q;
	logic [KEPT_W-1:0] drain_left_q;
	logic [CNT_W-1:0]  found_q;
	logic [CNT_W-1:0]  applied_q;
	logic              res_valid_q;
	out_item_t         res_q;

	// chain
	entry_t            ents  [DEPTH];
	logic [DEPTH-1:0]  cmp_v;
	logic [DEPTH-1:0]  gt_v;
	logic [DEPTH-1:0]  occ_v;
	logic [DEPTH-1:0]  hit_v;
	cell_ctl_t         ctl;
	entry_t            new_ent;

	logic              add_go;
	logic              drain_go;
	logic              drain_emit;
	logic [LIM_W-1:0]  lim_raw;
	logic [KEPT_W-1:0] lim;
	logic              full;
	logic [KEPT_W-1:0] count_eff;
	logic              acc;
	logic [KEPT_W-1:0] cnt_after;
	logic              wr_en;

	assign busy      = drain_left_q != '0;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign pready    = 1'b1;
	assign wr_en     = psel && penable && pwrite;

	assign add_go     = start && !busy && (req.func == FUNC_ADD);
	assign drain_go   = start && !busy && (req.func == FUNC_DRAIN);
	// a beat of a non-empty drain leaves cell 0 this cycle
	assign drain_emit = (drain_go && count_q != '0) || busy;

	assign new_ent.handle = req.handle;
	assign new_ent.score  = req.score;

	// Effective limit: initial mode uses the full depth, else the selected
	// register clamped into 1..DEPTH.
	always_comb begin
		lim_raw = req.at_root ? lim_root_q : lim_else_q;
		if (init_q) begin
			lim = DEPTH_K;
		end else if (lim_raw == '0) begin
			lim = KEPT_W'(1);
		end else if (KEPT_W'(lim_raw) > DEPTH_K) begin
			lim = DEPTH_K;
		end else begin
			lim = KEPT_W'(lim_raw);
		end
		full      = count_q >= lim;
		// a list left above a lowered limit is cut to limit-1 before insertion
		count_eff = full ? lim - KEPT_W'(1) : count_q;
		acc       = !full || (|hit_v);
		cnt_after = acc ? count_eff + KEPT_W'(1) : count_q;
	end

	assign ctl.add_en   = add_go && acc;
	assign ctl.drain_en = drain_emit;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ_v[i] = KEPT_W'(i) < count_eff;
		// candidate against the entry at position limit-1
		assign hit_v[i] = cmp_v[i] && (lim == KEPT_W'(i + 1));

		tks_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_ent   (new_ent),
			.occupied  (occ_v[i]),
			.prev_gt   ((i == 0) ? 1'b0 : gt_v[(i == 0) ? 0 : i - 1]),
			.left_ent  (ents[(i == 0) ? 0 : i - 1]),
			.right_ent (ents[(i == DEPTH - 1) ? i : i + 1]),
			.ent       (ents[i]),
			.cmp       (cmp_v[i]),
			.gt        (gt_v[i])
		);
	end

	// register read
	always_comb begin
		case (paddr[3:2])
			REG_LIMIT_ROOT: prdata = DATA_W'(lim_root_q);
			REG_LIMIT_ELSE: prdata = DATA_W'(lim_else_q);
			REG_INIT_MODE:  prdata = DATA_W'(init_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_root_q <= LIM_W'(32);
			lim_else_q <= LIM_W'(32);
			init_q     <= 1'b0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_LIMIT_ROOT: lim_root_q <= pwdata[LIM_W-1:0];
				REG_LIMIT_ELSE: lim_else_q <= pwdata[LIM_W-1:0];
				REG_INIT_MODE:  init_q     <= pwdata[0];
				default:        ;
			endcase
		end
	end

	// control state and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			drain_left_q <= '0;
			found_q      <= '0;
			applied_q    <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= add_go || drain_go || busy;
			if (add_go) begin
				count_q <= cnt_after;
				if (!init_q) begin
					found_q <= sat_inc(found_q);
				end
			end else if (drain_go) begin
				count_q <= '0;
				if (count_q != '0) begin
					drain_left_q <= count_q - KEPT_W'(1);
				end
			end else if (busy) begin
				drain_left_q <= drain_left_q - KEPT_W'(1);
			end
			if (drain_emit && !init_q) begin
				applied_q <= sat_inc(applied_q);
			end
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		if (add_go) begin
			res_q.out_handle    <= req.handle;
			res_q.out_score     <= req.score;
			res_q.accepted      <= acc;
			res_q.was_empty     <= 1'b0;
			res_q.last          <= 1'b1;
			res_q.kept_count    <= cnt_after;
			res_q.found_total   <= init_q ? found_q : sat_inc(found_q);
			res_q.applied_total <= applied_q;
		end else if (drain_emit) begin
			res_q.out_handle    <= ents[0].handle;
			res_q.out_score     <= ents[0].score;
			res_q.accepted      <= 1'b0;
			res_q.was_empty     <= 1'b0;
			res_q.last          <= busy ? (drain_left_q == KEPT_W'(1))
			                            : (count_q == KEPT_W'(1));
			res_q.kept_count    <= '0;
			res_q.found_total   <= found_q;
			res_q.applied_total <= init_q ? applied_q : sat_inc(applied_q);
		end else if (drain_go) begin
			res_q.out_handle    <= '0;
			res_q.out_score     <= '0;
			res_q.accepted      <= 1'b0;
			res_q.was_empty     <= 1'b1;
			res_q.last          <= 1'b1;
			res_q.kept_count    <= '0;
			res_q.found_total   <= found_q;
			res_q.applied_total <= applied_q;
		end
	end

endmodule

FILE: hw/rtl/tks_checker.sv
// ----------------------------------------------------------------------------
// tks_checker: port-level checks of the top-K score store
// Watches command and result beats; bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tks_checker import tks_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      res_valid,
	input out_item_t res
);

	// every taken command answers on the next cycle
	`ASSERT_NEXT(a_cmd_answered, clk, arst_n, start && !busy, res_valid)
	// a drain in progress keeps producing beats
	`ASSERT_NEXT(a_busy_beats, clk, arst_n, busy, res_valid)
	// beats of one drain run back to back until the last one
	`ASSERT_NEXT(a_drain_contig, clk, arst_n, res_valid && !res.last, res_valid && (busy || res.last))
	// an empty drain is a single, final beat
	`ASSERT_IMPLIES(a_empty_last, clk, arst_n, res_valid && res.was_empty, res.last)
	// an accepted candidate leaves at least one entry kept
	`ASSERT_IMPLIES(a_acc_kept, clk, arst_n, res_valid && res.accepted, res.kept_count != '0)

endmodule

bind top_k_score_store tks_checker u_tks_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.res_valid (res_valid),
	.res       (res)
);
